[rtl/mfc_pkg.sv]
package mfc_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned DEF_RADIUS     = 2;

  localparam int unsigned VALUE_W    = 10;
  localparam int unsigned CFG_W_W    = 12;
  localparam int unsigned CFG_H_W    = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_W_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_H_W-1:0] RESET_HEIGHT = 13'd480;

  // Wide enough for the rank of any cell in the largest window.
  localparam int unsigned RANK_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // Control that travels with one window through the rank pipeline.
  typedef struct packed {
    logic              run_last;
    logic              frame_last;
    logic [RANK_W-1:0] half;
  } tag_t;

endpackage

[rtl/mfc_ram.sv]
module mfc_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mfc_rank.sv]
module mfc_rank #(
  parameter int unsigned CELLS = 25
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  vld_i,
  input  logic [CELLS*mfc_pkg::VALUE_W-1:0]     vals_i,
  input  logic [CELLS-1:0]                      mask_i,
  input  mfc_pkg::tag_t                         tag_i,
  output logic                                  vld_o,
  output logic [mfc_pkg::VALUE_W-1:0]           value_o,
  output mfc_pkg::tag_t                         tag_o
);

  localparam int unsigned VW = mfc_pkg::VALUE_W;

  // Stage one: pairwise comparison matrix. Ties are broken by cell index, so
  // the ranks of the valid cells form a permutation.
  logic [CELLS-1:0]    lt_d [CELLS];
  logic [CELLS-1:0]    lt_q [CELLS];
  logic [CELLS*VW-1:0] vals_q;
  logic [CELLS-1:0]    mask_q;
  mfc_pkg::tag_t       tag_q;
  logic                vld_q;

  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      for (int j = 0; j < CELLS; j++) begin
        lt_d[i][j] = mask_i[j] &&
                     ((vals_i[j*VW +: VW] < vals_i[i*VW +: VW]) ||
                      ((vals_i[j*VW +: VW] == vals_i[i*VW +: VW]) && (j < i)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lt_q   <= lt_d;
      vals_q <= vals_i;
      mask_q <= mask_i;
      tag_q  <= tag_i;
    end
  end

  // Stage two: count each row of the matrix and pick the cell whose rank is
  // half the population.
  logic [CELLS-1:0] sel;
  logic [VW-1:0]    value_d;

  always_comb begin
    logic [mfc_pkg::RANK_W-1:0] rank;
    value_d = '0;
    for (int i = 0; i < CELLS; i++) begin
      rank = '0;
      for (int j = 0; j < CELLS; j++) begin
        rank = rank + mfc_pkg::RANK_W'(lt_q[i][j]);
      end
      sel[i] = mask_q[i] && (rank == tag_q.half);
      value_d = value_d | (sel[i] ? vals_q[i*VW +: VW] : '0);
    end
  end

  logic          vld_out_q;
  logic [VW-1:0] value_q;
  mfc_pkg::tag_t tag_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_out_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q   <= value_d;
      tag_out_q <= tag_q;
    end
  end

  assign vld_o   = vld_out_q;
  assign value_o = value_q;
  assign tag_o   = tag_out_q;

endmodule

[rtl/median_filter_5x5_clipped.sv]
// Streaming median over a (2R+1) x (2R+1) window clipped at the frame edges.
// One difference word is taken per clock. A pixel completes at most one
// result, except that the last pixel of a row and any pixel of the last row
// complete up to R+1 results and the final pixel of the frame up to
// (R+1)*(R+1). The input stalls while the extra results are issued, since the
// shared rank pipeline takes one window per clock, and for as long as the
// output is held. Once the word that completes a result is accepted, the
// result passes window update, clipping, comparison matrix and rank
// select, in that order. The line store keeps the previous 2R rows as one
// packed column per pixel position, read for each word and again while it
// is held, written back once per word; it needs no clearing after reset.
module median_filter_5x5_clipped #(
  parameter int unsigned MAX_WIDTH     = mfc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = mfc_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned WINDOW_RADIUS = mfc_pkg::DEF_RADIUS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mfc_pkg::VALUE_W-1:0]       diff_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mfc_pkg::VALUE_W-1:0]       median_value_o,
  output logic                              run_last_o,
  output logic                              frame_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned VW    = mfc_pkg::VALUE_W;
  localparam int unsigned R     = WINDOW_RADIUS;
  localparam int unsigned S     = 2 * R + 1;
  localparam int unsigned CELLS = S * S;
  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HHW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW    = $clog2(R + 1);
  localparam int unsigned PW    = $clog2(S);
  localparam int unsigned LW    = (S - 1) * VW;

  // Configuration
  logic [mfc_pkg::CFG_W_W-1:0] cfg_w_q;
  logic [mfc_pkg::CFG_H_W-1:0] cfg_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= mfc_pkg::RESET_WIDTH;
      cfg_h_q <= mfc_pkg::RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (mfc_pkg::cfg_idx_e'(cfg_index_i))
        mfc_pkg::CFG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i[mfc_pkg::CFG_W_W-1:0];
        mfc_pkg::CFG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i[mfc_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0]  w_eff;
  logic [HHW-1:0] h_eff;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HHW'(1);
    end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HHW'(MAX_HEIGHT);
    end else begin
      h_eff = HHW'(cfg_h_q);
    end
  end

  // Pipeline control
  logic en;
  logic in_accept;
  logic i1_adv;

  assign en        = !(out_valid_o && out_stall_i);
  assign in_accept = in_valid_i && !in_stall_o;

  // Input position
  logic [AW-1:0] in_col_q, in_col_d;
  logic [HW-1:0] in_row_q, in_row_d;
  logic [AW-1:0] ix_now;
  logic [HW-1:0] iy_now;
  logic          col_last, row_last;

  always_comb begin
    if (32'(in_col_q) >= 32'(w_eff) || 32'(in_row_q) >= 32'(h_eff)) begin
      ix_now = '0;
      iy_now = '0;
    end else begin
      ix_now = in_col_q;
      iy_now = in_row_q;
    end
    col_last = (32'(ix_now) + 32'd1) >= 32'(w_eff);
    row_last = (32'(iy_now) + 32'd1) >= 32'(h_eff);
    if (col_last) begin
      in_col_d = '0;
      in_row_d = row_last ? '0 : iy_now + HW'(1);
    end else begin
      in_col_d = ix_now + AW'(1);
      in_row_d = iy_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (in_accept) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  // Result range of the accepted word, as offsets back from its position.
  logic          any_d;
  logic [DW-1:0] dyhi_d, dylo_d, dxhi_d, dxlo_d;
  logic [PW-1:0] iyc_d, ixc_d;

  always_comb begin
    logic row_any, col_any;
    if (row_last) begin
      row_any = 1'b1;
      dyhi_d  = (32'(iy_now) >= R) ? DW'(R) : DW'(iy_now);
      dylo_d  = '0;
    end else begin
      row_any = 32'(iy_now) >= R;
      dyhi_d  = DW'(R);
      dylo_d  = DW'(R);
    end
    if (col_last) begin
      col_any = 1'b1;
      dxhi_d  = (32'(ix_now) >= R) ? DW'(R) : DW'(ix_now);
      dxlo_d  = '0;
    end else begin
      col_any = 32'(ix_now) >= R;
      dxhi_d  = DW'(R);
      dxlo_d  = DW'(R);
    end
    any_d = row_any && col_any;
    iyc_d = (32'(iy_now) >= 2 * R) ? PW'(2 * R) : PW'(iy_now);
    ixc_d = (32'(ix_now) >= 2 * R) ? PW'(2 * R) : PW'(ix_now);
  end

  // Stage I1: the word waits here for its column from the line store.
  logic          i1_vld_q;
  logic [VW-1:0] i1_val_q;
  logic [AW-1:0] i1_addr_q;
  logic          i1_any_q, i1_clast_q, i1_rlast_q;
  logic [DW-1:0] i1_dyhi_q, i1_dylo_q, i1_dxhi_q, i1_dxlo_q;
  logic [PW-1:0] i1_iyc_q, i1_ixc_q;

  assign in_stall_o = i1_vld_q && !i1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i1_vld_q <= 1'b0;
    end else if (in_accept) begin
      i1_vld_q <= 1'b1;
    end else if (i1_adv) begin
      i1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      i1_val_q   <= diff_value_i;
      i1_addr_q  <= ix_now;
      i1_any_q   <= any_d;
      i1_clast_q <= col_last;
      i1_rlast_q <= row_last;
      i1_dyhi_q  <= dyhi_d;
      i1_dylo_q  <= dylo_d;
      i1_dxhi_q  <= dxhi_d;
      i1_dxlo_q  <= dxlo_d;
      i1_iyc_q   <= iyc_d;
      i1_ixc_q   <= ixc_d;
    end
  end

  // Line store: one packed column of the previous 2R rows per position.
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata, ram_wdata;
  logic          fwd_hit_q;
  logic [LW-1:0] fwd_data_q;
  logic [LW-1:0] old_col;
  logic [VW-1:0] col [S];

  // A held word reads its own address again every cycle.
  assign ram_raddr = in_stall_o ? i1_addr_q : ix_now;

  mfc_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (i1_adv),
    .waddr_i (i1_addr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A write to the address being read in the same cycle is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= i1_adv && (i1_addr_q == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
  end

  assign old_col = fwd_hit_q ? fwd_data_q : ram_rdata;

  always_comb begin
    for (int r = 0; r < S - 1; r++) begin
      col[r] = old_col[r*VW +: VW];
    end
    col[S-1] = i1_val_q;
    for (int k = 0; k < S - 1; k++) begin
      ram_wdata[k*VW +: VW] = col[k+1];
    end
  end

  // Window and result sequencer. Row S-1 and column S-1 hold the newest word.
  logic [VW-1:0] win_q [S][S];
  logic          jact_q, jact_d;
  logic [DW-1:0] jd_dylo_q, jd_dxhi_q, jd_dxlo_q;
  logic [DW-1:0] cur_dy_q, cur_dy_d, cur_dx_q, cur_dx_d;
  logic [PW-1:0] jd_iyc_q, jd_ixc_q;
  logic          jd_clast_q, jd_rlast_q;
  logic          issue, job_last;

  assign issue    = jact_q && en;
  assign job_last = (cur_dy_q == jd_dylo_q) && (cur_dx_q == jd_dxlo_q);
  assign i1_adv   = i1_vld_q && en && (!jact_q || job_last);

  always_comb begin
    jact_d   = jact_q;
    cur_dy_d = cur_dy_q;
    cur_dx_d = cur_dx_q;
    if (i1_adv) begin
      jact_d   = i1_any_q;
      cur_dy_d = i1_dyhi_q;
      cur_dx_d = i1_dxhi_q;
    end else if (issue) begin
      if (job_last) begin
        jact_d = 1'b0;
      end else if (cur_dx_q == jd_dxlo_q) begin
        cur_dx_d = jd_dxhi_q;
        cur_dy_d = cur_dy_q - DW'(1);
      end else begin
        cur_dx_d = cur_dx_q - DW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jact_q <= 1'b0;
    end else begin
      jact_q <= jact_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_dy_q <= cur_dy_d;
    cur_dx_q <= cur_dx_d;
    if (i1_adv) begin
      jd_dylo_q  <= i1_dylo_q;
      jd_dxhi_q  <= i1_dxhi_q;
      jd_dxlo_q  <= i1_dxlo_q;
      jd_iyc_q   <= i1_iyc_q;
      jd_ixc_q   <= i1_ixc_q;
      jd_clast_q <= i1_clast_q;
      jd_rlast_q <= i1_rlast_q;
      for (int r = 0; r < S; r++) begin
        for (int c = 0; c < S - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
        win_q[r][S-1] <= col[r];
      end
    end
  end

  // Clip the window for the current result: a row or column counts when it
  // lies inside the frame and within the radius of the result's centre.
  logic [CELLS-1:0]    mask_d;
  logic [CELLS*VW-1:0] vals_d;
  mfc_pkg::tag_t       tag_d;

  always_comb begin
    logic [S-1:0] rowm, colm;
    logic [PW:0]  nr, nc;
    logic [2*PW+1:0] prod;
    nr = '0;
    nc = '0;
    for (int r = 0; r < S; r++) begin
      rowm[r] = (r + int'(cur_dy_q) >= R) && (int'(jd_iyc_q) + r >= 2 * R);
      colm[r] = (r + int'(cur_dx_q) >= R) && (int'(jd_ixc_q) + r >= 2 * R);
      nr = nr + (PW+1)'(rowm[r]);
      nc = nc + (PW+1)'(colm[r]);
    end
    for (int r = 0; r < S; r++) begin
      for (int c = 0; c < S; c++) begin
        mask_d[r*S+c]            = rowm[r] && colm[c];
        vals_d[(r*S+c)*VW +: VW] = win_q[r][c];
      end
    end
    prod             = (2*PW+2)'(nr) * (2*PW+2)'(nc);
    tag_d.half       = mfc_pkg::RANK_W'(prod >> 1);
    tag_d.run_last   = job_last;
    tag_d.frame_last = jd_clast_q && jd_rlast_q && (cur_dx_q == '0) && (cur_dy_q == '0);
  end

  logic                p1_vld_q;
  logic [CELLS-1:0]    p1_mask_q;
  logic [CELLS*VW-1:0] p1_vals_q;
  mfc_pkg::tag_t       p1_tag_q;
  mfc_pkg::tag_t       out_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= jact_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_mask_q <= mask_d;
      p1_vals_q <= vals_d;
      p1_tag_q  <= tag_d;
    end
  end

  mfc_rank #(
    .CELLS (CELLS)
  ) u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (p1_vld_q),
    .vals_i  (p1_vals_q),
    .mask_i  (p1_mask_q),
    .tag_i   (p1_tag_q),
    .vld_o   (out_valid_o),
    .value_o (median_value_o),
    .tag_o   (out_tag)
  );

  assign run_last_o   = out_tag.run_last;
  assign frame_last_o = out_tag.frame_last;

  // Checks
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !i1_vld_q |-> !in_stall_o)
    else $error("input stalled with no word waiting");

  a_half_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q |-> (32'(p1_tag_q.half) < 32'($countones(p1_mask_q))))
    else $error("median rank outside the clipped window");

  a_seq_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jact_q |-> (cur_dy_q >= jd_dylo_q) && (cur_dx_q >= jd_dxlo_q))
    else $error("result sequencer ran past its range");

endmodule

[tb/median_filter_5x5_clipped_tb.sv]
`timescale 1ns / 1ps

module median_filter_5x5_clipped_tb;

  localparam int unsigned VW     = mfc_pkg::VALUE_W;
  localparam int unsigned LINE_W = mfc_pkg::DEF_MAX_WIDTH;
  localparam int unsigned SLOTS  = 2 * mfc_pkg::DEF_RADIUS + 1;
  localparam int unsigned RAD    = mfc_pkg::DEF_RADIUS;

  typedef struct {
    logic [VW-1:0] median;
    logic          run_last;
    logic          frame_last;
  } median_result_t;

  // Keeps its own copy of the frame geometry and of the recent rows, and
  // works out the medians that each accepted word completes.
  class median_scoreboard;
    logic [VW-1:0]                   rows_seen [SLOTS*LINE_W];
    logic [mfc_pkg::CFG_W_W-1:0]     width_reg;
    logic [mfc_pkg::CFG_H_W-1:0]     height_reg;
    int unsigned                     next_col, next_row;
    median_result_t                  awaited [$];
    int unsigned                     errors, checked, words;

    function new();
      width_reg  = mfc_pkg::RESET_WIDTH;
      height_reg = mfc_pkg::RESET_HEIGHT;
      next_col = 0; next_row = 0;
      errors = 0; checked = 0; words = 0;
    endfunction

    function void write_reg(mfc_pkg::cfg_idx_e idx, logic [mfc_pkg::CFG_DATA_W-1:0] data);
      if (idx == mfc_pkg::CFG_FRAME_WIDTH) width_reg = data[mfc_pkg::CFG_W_W-1:0];
      else height_reg = data[mfc_pkg::CFG_H_W-1:0];
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > mfc_pkg::DEF_MAX_WIDTH) return mfc_pkg::DEF_MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > mfc_pkg::DEF_MAX_HEIGHT) return mfc_pkg::DEF_MAX_HEIGHT;
      return height_reg;
    endfunction

    function logic [VW-1:0] window_median(int unsigned ox, int unsigned oy,
                                          int unsigned w, int unsigned h);
      logic [VW-1:0] vals [25];
      logic [VW-1:0] v;
      int unsigned y0, y1, x0, x1, n, i;
      y0 = (oy > RAD) ? oy - RAD : 0;
      y1 = (oy + RAD < h - 1) ? oy + RAD : h - 1;
      x0 = (ox > RAD) ? ox - RAD : 0;
      x1 = (ox + RAD < w - 1) ? ox + RAD : w - 1;
      n = 0;
      for (int unsigned sy = y0; sy <= y1; sy++) begin
        for (int unsigned sx = x0; sx <= x1; sx++) begin
          v = rows_seen[(sy % SLOTS) * LINE_W + sx];
          i = n;
          while (i > 0 && vals[i-1] > v) begin
            vals[i] = vals[i-1];
            i--;
          end
          vals[i] = v;
          n++;
        end
      end
      return vals[n/2];
    endfunction

    function void note_input(logic [VW-1:0] word);
      int unsigned w, h, rlo, rhi, clo, chi;
      bit any_row, any_col;
      median_result_t res;
      w = eff_width();
      h = eff_height();
      words++;
      if (next_col >= w || next_row >= h) begin
        next_col = 0;
        next_row = 0;
      end
      rows_seen[(next_row % SLOTS) * LINE_W + next_col] = word;
      if (next_row + 1 < h) begin
        any_row = next_row >= RAD;
        rlo = any_row ? next_row - RAD : 0;
        rhi = rlo;
      end else begin
        any_row = 1;
        rlo = (next_row >= RAD) ? next_row - RAD : 0;
        rhi = next_row;
      end
      if (next_col + 1 < w) begin
        any_col = next_col >= RAD;
        clo = any_col ? next_col - RAD : 0;
        chi = clo;
      end else begin
        any_col = 1;
        clo = (next_col >= RAD) ? next_col - RAD : 0;
        chi = next_col;
      end
      if (any_row && any_col) begin
        for (int unsigned oy = rlo; oy <= rhi; oy++) begin
          for (int unsigned ox = clo; ox <= chi; ox++) begin
            res.median     = window_median(ox, oy, w, h);
            res.run_last   = (oy == rhi && ox == chi);
            res.frame_last = (ox == w - 1 && oy == h - 1);
            awaited.insert(awaited.size(), res);
          end
        end
      end
      next_col++;
      if (next_col >= w) begin
        next_col = 0;
        next_row++;
        if (next_row >= h) next_row = 0;
      end
    endfunction

    function void check_result(logic [VW-1:0] med, logic rl, logic fl);
      median_result_t exp_r;
      checked++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result median=%0d run_last=%0b frame_last=%0b",
                 $realtime, med, rl, fl);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (med !== exp_r.median) begin
        $display("%0t: median_value expected %0d actual %0d", $realtime, exp_r.median, med);
        errors++;
      end
      if (rl !== exp_r.run_last) begin
        $display("%0t: run_last expected %0b actual %0b", $realtime, exp_r.run_last, rl);
        errors++;
      end
      if (fl !== exp_r.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b", $realtime,
                 exp_r.frame_last, fl);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [VW-1:0]                  diff_value_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [VW-1:0]                  median_value_o;
  logic                           run_last_o;
  logic                           frame_last_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [mfc_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  median_scoreboard sb = new();
  bit               hold_req = 0;
  bit               quiet = 0;
  int unsigned      frames_done = 0;

  always #1 clk_i = ~clk_i;

  median_filter_5x5_clipped dut (.*);

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(logic [VW-1:0] word);
    int unsigned gap;
    in_valid_i   <= 1'b1;
    diff_value_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(word);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Registers change only with the block idle; a few extra clocks cover the
  // pipeline depth after the last result has been seen.
  task automatic write_reg(mfc_pkg::cfg_idx_e idx, logic [mfc_pkg::CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [VW-1:0] random_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return VW'($urandom_range(765));
    if (r < 90) return VW'($urandom_range(1023, 766));
    return (r < 95) ? 10'd0 : 10'd765;
  endfunction

  task automatic run_frame(int unsigned w, int unsigned h, bit directed, int unsigned hold_at);
    int unsigned n;
    logic [VW-1:0] word;
    write_reg(mfc_pkg::CFG_FRAME_WIDTH, mfc_pkg::CFG_DATA_W'(w));
    write_reg(mfc_pkg::CFG_FRAME_HEIGHT, mfc_pkg::CFG_DATA_W'(h));
    n = sb.eff_width() * sb.eff_height();
    for (int unsigned k = 0; k < n; k++) begin
      if (directed) begin
        case (k % 6)
          0: word = 10'd0;
          1: word = 10'd765;
          2: word = 10'd1023;
          3: word = 10'd766;
          4: word = 10'h155;
          default: word = 10'h2AA;
        endcase
      end else begin
        word = random_word();
      end
      if (k == hold_at) hold_req = 1;
      send_word(word);
    end
    frames_done++;
  endtask

  initial begin
    int unsigned w, h;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: smallest frames, clamped zero sizes, edge values.
    run_frame(1, 1, 1, '1);
    run_frame(0, 0, 1, '1);
    run_frame(5, 4, 1, '1);
    // Long receiver hold while words keep coming, so the input backs up.
    run_frame(8, 8, 0, 5);
    // Sender waits for every result, then sends a quiet frame with no input gaps.
    in_valid_i <= 1'b0;
    drain();
    quiet = 1;
    run_frame(6, 3, 0, '1);
    quiet = 0;
    while (sb.words < 235) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(16, 13) : $urandom_range(12, 1);
      h = $urandom_range(5, 1);
      quiet = ($urandom_range(4) == 0);
      run_frame(w, h, 0, '1);
    end
    quiet = 0;
    in_valid_i <= 1'b0;
    drain();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d frames of %0d words, %0d medians checked, sizes from 1x1 up to",
             frames_done, sb.words, sb.checked);
    $display("16 wide, zero sizes clamped, with a long output hold and gaps on both sides.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("median_filter_5x5_clipped_tb: PASS");
    end else begin
      $display("median_filter_5x5_clipped_tb: FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left, stall_left, r;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(median_value_o, run_last_o, frame_last_o);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (quiet || r < 65) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (r < 94) ? $urandom_range(2) : $urandom_range(40, 10);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("median_filter_5x5_clipped_tb: FAIL");
    $finish;
  end

endmodule
